FILE: sv/rsec_pkg.sv
// rsec_pkg: opcode, function and command codes and shared types of the
// RV32 subset execute core. No dependencies.
`default_nettype none
package rsec_pkg;
  localparam int DMEM_BYTES_DEF = 4096;

  localparam logic [6:0] OP_R      = 7'b0110011;
  localparam logic [6:0] OP_IMM    = 7'b0010011;
  localparam logic [6:0] OP_JALR   = 7'b1100111;
  localparam logic [6:0] OP_LOAD   = 7'b0000011;
  localparam logic [6:0] OP_STORE  = 7'b0100011;
  localparam logic [6:0] OP_BRANCH = 7'b1100011;
  localparam logic [6:0] OP_JAL    = 7'b1101111;
  localparam logic [6:0] OP_AUIPC  = 7'b0010111;
  localparam logic [6:0] OP_LUI    = 7'b0110111;

  localparam logic [6:0] F7_BASE   = 7'b0000000;
  localparam logic [6:0] F7_MULDIV = 7'b0000001;
  localparam logic [6:0] F7_ALT    = 7'b0100000;

  localparam logic [2:0] F3_ADD = 3'd0;
  localparam logic [2:0] F3_BNE = 3'd1;
  localparam logic [2:0] F3_WORD = 3'd2;
  localparam logic [2:0] F3_XOR = 3'd4;
  localparam logic [2:0] F3_OR  = 3'd6;
  localparam logic [2:0] F3_AND = 3'd7;
  localparam logic [2:0] F3_DIV = 3'd4;
  localparam logic [2:0] F3_REM = 3'd6;

  localparam logic CMD_EXEC    = 1'b0;
  localparam logic CMD_PRELOAD = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;
endpackage
`default_nettype wire

FILE: sv/rv32_subset_execute_core.sv
// rv32_subset_execute_core: sequenced RV32 subset execute core.
// Depends on rsec_pkg, rsec_regfile, rsec_dmem, rsec_div.
//
//  channel | dir | ports                          | contents
//  in      | in  | in_tvalid/tready/tdata/tuser   | one command word
//  out     | out | out_tvalid/tready/tdata/tuser  | one result word per command
//
// Steps per word: accept in S_IDLE, register read in S_READ, execute in S_EXEC,
// result out from S_RESP; sb writes one byte in S_MWR, sw and preload four, lw
// reads four via S_MRD/S_MRDW; div, rem wait in S_DIV for the one-bit-per-cycle
// divider. Data memory is one byte port, so word accesses walk four bytes.
// After reset the data memory is cleared one byte a cycle, with in_tready low.
// in_tready is high only while the sequencer is idle; a result held by a
// stalled out_tready blocks the next result, not the accept.
`default_nettype none
module rv32_subset_execute_core import rsec_pkg::*; #(
  parameter int DMEM_BYTES = DMEM_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [31:0] instr_word, [43:32] load_addr, [75:44] load_data, zero pad
  input  wire logic [79:0] in_tdata,
  // [0] cmd
  input  wire logic [0:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [31:0] next_pc, [32] reg_written, [37:33] dest_index, [69:38] dest_value
  output logic [71:0]      out_tdata,
  // [0] illegal
  output logic [0:0]       out_tuser
);
  localparam int AW = $clog2(DMEM_BYTES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_DIV, S_MRD, S_MRDW, S_MWR, S_RESP
  } state_t;

  state_t      state_r, state_nxt;
  logic [31:0] pc_r, pc_nxt, instr_r, instr_nxt, ldata_r, ldata_nxt;
  logic [11:0] laddr_r, laddr_nxt;
  logic        cmd_r, cmd_nxt;
  logic [31:0] ea_r, ea_nxt, sdata_r, sdata_nxt, npc_r, npc_nxt, val_r, val_nxt;
  logic        wr_r, wr_nxt;
  logic [1:0]  blen_r, blen_nxt, bcnt_r, bcnt_nxt;
  logic [69:0] pend_r, pend_nxt;
  logic        pill_r, pill_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [69:0] odata_r, odata_nxt;
  logic        oill_r, oill_nxt;

  // shared datapath nets
  logic [31:0] rs1_v, rs2_v;
  logic        rf_we;
  logic [31:0] rf_wd;
  logic        mem_we, mem_ready;
  logic [AW-1:0] mem_addr;
  logic [7:0]  mem_wdata, mem_rdata;
  logic        div_start;
  logic [31:0] div_q, div_r;
  div_stat_t   div_stat;

  // finish step
  logic        fin, fin_wr, fin_bad, fin_written;
  logic [31:0] fin_val, fin_npc;

  // decode
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [4:0]  rd;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, mul_lo;

  assign op = instr_r[6:0];
  assign rd = instr_r[11:7];
  assign f3 = instr_r[14:12];
  assign f7 = instr_r[31:25];
  assign imm_i = {{20{instr_r[31]}}, instr_r[31:20]};
  assign imm_s = {{20{instr_r[31]}}, instr_r[31:25], instr_r[11:7]};
  assign imm_b = {{19{instr_r[31]}}, instr_r[31], instr_r[7], instr_r[30:25],
                  instr_r[11:8], 1'b0};
  assign imm_j = {{11{instr_r[31]}}, instr_r[31], instr_r[19:12], instr_r[20],
                  instr_r[30:21], 1'b0};
  assign imm_u = {instr_r[31:12], 12'd0};
  assign mul_lo = rs1_v * rs2_v;

  rsec_regfile u_rf (
    .clk(clk), .rst_n(rst_n),
    .ra1(instr_r[19:15]), .ra2(instr_r[24:20]),
    .rd1(rs1_v), .rd2(rs2_v),
    .we(rf_we), .wa(rd), .wd(rf_wd)
  );

  rsec_dmem #(.DMEM_BYTES(DMEM_BYTES)) u_dmem (
    .clk(clk), .rst_n(rst_n), .we(mem_we), .addr(mem_addr),
    .wdata(mem_wdata), .rdata(mem_rdata), .ready(mem_ready)
  );

  rsec_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .a(rs1_v), .b(rs2_v),
    .quo(div_q), .rem(div_r), .stat(div_stat)
  );

  assign in_tready = (state_r == S_IDLE);
  assign mem_addr  = AW'(ea_r + {30'd0, bcnt_r});
  assign mem_wdata = sdata_r[{bcnt_r, 3'b000} +: 8];

  always_comb begin
    state_nxt = state_r;
    pc_nxt = pc_r; instr_nxt = instr_r; cmd_nxt = cmd_r;
    laddr_nxt = laddr_r; ldata_nxt = ldata_r;
    ea_nxt = ea_r; sdata_nxt = sdata_r; npc_nxt = npc_r; val_nxt = val_r;
    wr_nxt = wr_r; blen_nxt = blen_r; bcnt_nxt = bcnt_r;
    pend_nxt = pend_r; pill_nxt = pill_r;
    ovalid_nxt = ovalid_r; odata_nxt = odata_r; oill_nxt = oill_r;
    mem_we = 1'b0; div_start = 1'b0;
    fin = 1'b0; fin_wr = 1'b0; fin_bad = 1'b0;
    fin_val = 32'd0; fin_npc = pc_r;

    if (ovalid_r && out_tready) ovalid_nxt = 1'b0;

    case (state_r)
      S_CLEAR: if (mem_ready) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          instr_nxt = in_tdata[31:0];
          laddr_nxt = in_tdata[43:32];
          ldata_nxt = in_tdata[75:44];
          cmd_nxt   = in_tuser[0];
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        bcnt_nxt = 2'd0;
        npc_nxt  = pc_r + 32'd4;
        wr_nxt   = 1'b0;
        if (cmd_r == CMD_PRELOAD) begin
          ea_nxt = {20'd0, laddr_r}; sdata_nxt = ldata_r; blen_nxt = 2'd3;
          npc_nxt = pc_r; state_nxt = S_MWR;
        end else begin
          case (op)
            OP_R: begin
              fin = 1'b1; fin_wr = 1'b1; fin_npc = pc_r + 32'd4;
              if (f7 == F7_BASE && f3 == F3_ADD) fin_val = rs1_v + rs2_v;
              else if (f7 == F7_ALT && f3 == F3_ADD) fin_val = rs1_v - rs2_v;
              else if (f7 == F7_BASE && f3 == F3_XOR) fin_val = rs1_v ^ rs2_v;
              else if (f7 == F7_BASE && f3 == F3_AND) fin_val = rs1_v & rs2_v;
              else if (f7 == F7_MULDIV && f3 == F3_ADD) fin_val = mul_lo;
              else if (f7 == F7_MULDIV && (f3 == F3_DIV || f3 == F3_REM)) begin
                fin = 1'b0; div_start = 1'b1; state_nxt = S_DIV;
              end else fin_bad = 1'b1;
            end
            OP_IMM: begin
              fin = 1'b1; fin_wr = 1'b1; fin_npc = pc_r + 32'd4;
              if (f3 == F3_ADD) fin_val = rs1_v + imm_i;
              else if (f3 == F3_OR) fin_val = rs1_v | imm_i;
              else fin_bad = 1'b1;
            end
            OP_LOAD: begin
              if (f3 == F3_WORD) begin
                ea_nxt = rs1_v + imm_i; wr_nxt = 1'b1; state_nxt = S_MRD;
              end else begin
                fin = 1'b1; fin_bad = 1'b1;
              end
            end
            OP_JALR: begin
              fin = 1'b1; fin_wr = 1'b1; fin_val = pc_r + 32'd4;
              fin_npc = (rs1_v + imm_i) & ~32'd1;
              if (f3 != F3_ADD) fin_bad = 1'b1;
            end
            OP_STORE: begin
              ea_nxt = rs1_v + imm_s; sdata_nxt = rs2_v;
              if (f3 == F3_ADD) begin
                blen_nxt = 2'd0; state_nxt = S_MWR;
              end else if (f3 == F3_WORD) begin
                blen_nxt = 2'd3; state_nxt = S_MWR;
              end else begin
                fin = 1'b1; fin_bad = 1'b1;
              end
            end
            OP_BRANCH: begin
              fin = 1'b1; fin_npc = pc_r + 32'd4;
              if (f3 == F3_ADD) begin
                if (rs1_v == rs2_v) fin_npc = pc_r + imm_b;
              end else if (f3 == F3_BNE) begin
                if (rs1_v != rs2_v) fin_npc = pc_r + imm_b;
              end else fin_bad = 1'b1;
            end
            OP_LUI: begin
              fin = 1'b1; fin_wr = 1'b1; fin_val = imm_u; fin_npc = pc_r + 32'd4;
            end
            OP_AUIPC: begin
              fin = 1'b1; fin_wr = 1'b1; fin_val = pc_r + imm_u;
              fin_npc = pc_r + 32'd4;
            end
            OP_JAL: begin
              fin = 1'b1; fin_wr = 1'b1; fin_val = pc_r + 32'd4;
              fin_npc = pc_r + imm_j;
            end
            default: begin
              fin = 1'b1; fin_bad = 1'b1;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          fin = 1'b1; fin_wr = 1'b1; fin_npc = npc_r;
          fin_val = (f3 == F3_REM) ? div_r : div_q;
        end
      end
      S_MRD: state_nxt = S_MRDW;
      S_MRDW: begin
        val_nxt[{bcnt_r, 3'b000} +: 8] = mem_rdata;
        if (bcnt_r == 2'd3) begin
          fin = 1'b1; fin_wr = wr_r; fin_npc = npc_r;
          fin_val = {mem_rdata, val_r[23:0]};
        end else begin
          bcnt_nxt = bcnt_r + 2'd1; state_nxt = S_MRD;
        end
      end
      S_MWR: begin
        mem_we = 1'b1;
        if (bcnt_r == blen_r) begin
          fin = 1'b1; fin_npc = npc_r;
        end else bcnt_nxt = bcnt_r + 2'd1;
      end
      S_RESP: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1; odata_nxt = pend_r; oill_nxt = pill_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase

    // commit: illegal words change nothing, x0 never written
    if (fin) begin
      if (!fin_bad) pc_nxt = fin_npc;
      pend_nxt  = {fin_written ? fin_val : 32'd0, fin_written ? rd : 5'd0,
                   fin_written, fin_bad ? pc_r : fin_npc};
      pill_nxt  = fin_bad;
      state_nxt = S_RESP;
    end
  end

  assign fin_written = fin && fin_wr && !fin_bad && (rd != 5'd0);
  assign rf_we = fin_written;
  assign rf_wd = fin_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      pc_r     <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      pc_r     <= pc_nxt;
      ovalid_r <= ovalid_nxt;
    end
    instr_r <= instr_nxt; cmd_r <= cmd_nxt; laddr_r <= laddr_nxt;
    ldata_r <= ldata_nxt; ea_r <= ea_nxt; sdata_r <= sdata_nxt;
    npc_r <= npc_nxt; val_r <= val_nxt; wr_r <= wr_nxt;
    blen_r <= blen_nxt; bcnt_r <= bcnt_nxt;
    pend_r <= pend_nxt; pill_r <= pill_nxt;
    odata_r <= odata_nxt; oill_r <= oill_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {2'b00, odata_r};
  assign out_tuser  = oill_r;
endmodule
`default_nettype wire

FILE: sv/rsec_div.sv
// rsec_div: iterative signed 32-bit divider, one quotient bit per cycle.
// Depends on rsec_pkg.
`default_nettype none
module rsec_div import rsec_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic [31:0]      quo,
  output logic [31:0]      rem,
  output div_stat_t        stat
);
  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [31:0] rem_r, quo_r, ub_r, a_r;
  logic        na_r, nb_r, bz_r;
  logic [32:0] shifted, diff;

  assign shifted = {rem_r, quo_r[31]};
  assign diff    = shifted - {1'b0, ub_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= a[31] ? (32'd0 - a) : a;
      ub_r  <= b[31] ? (32'd0 - b) : b;
      na_r  <= a[31];
      nb_r  <= b[31];
      bz_r  <= (b == 32'd0);
      a_r   <= a;
    end else if (busy_r) begin
      if (!diff[32]) rem_r <= diff[31:0];
      else           rem_r <= shifted[31:0];
      quo_r <= {quo_r[30:0], ~diff[32]};
    end
  end

  // divide by zero: all ones and the dividend
  assign quo = bz_r ? '1 : ((na_r ^ nb_r) ? (32'd0 - quo_r) : quo_r);
  assign rem = bz_r ? a_r : (na_r ? (32'd0 - rem_r) : rem_r);
  assign stat.busy = busy_r;
  assign stat.done = done_r;
endmodule
`default_nettype wire

FILE: sv/rsec_regfile.sv
// rsec_regfile: 32 x 32 register file, two registered read ports, one write.
// Valid bits make unwritten entries read as zero after reset. Uses rsec_pkg.
`default_nettype none
module rsec_regfile import rsec_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [4:0]  ra1,
  input  wire logic [4:0]  ra2,
  output logic [31:0]      rd1,
  output logic [31:0]      rd2,
  input  wire logic        we,
  input  wire logic [4:0]  wa,
  input  wire logic [31:0] wd
);
  logic [31:0] mem [32];
  logic [31:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= '0;
    else if (we) valid_r[wa] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd1 <= valid_r[ra1] ? mem[ra1] : 32'd0;
    rd2 <= valid_r[ra2] ? mem[ra2] : 32'd0;
  end
endmodule
`default_nettype wire

FILE: sv/rsec_dmem.sv
// rsec_dmem: byte-wide data memory with registered read and a clearing
// pass after reset. Uses rsec_pkg. DMEM_BYTES is a power of two.
`default_nettype none
module rsec_dmem import rsec_pkg::*; #(
  parameter int DMEM_BYTES = DMEM_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          we,
  input  wire logic [$clog2(DMEM_BYTES)-1:0] addr,
  input  wire logic [7:0]                    wdata,
  output logic [7:0]                         rdata,
  output logic                               ready
);
  localparam int AW = $clog2(DMEM_BYTES);
  logic [7:0]    mem [DMEM_BYTES];
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(DMEM_BYTES - 1)) clearing_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) mem[clr_cnt_r] <= 8'd0;
    else if (we)    mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  assign ready = ~clearing_r;
endmodule
`default_nettype wire

FILE: sv/rsec_checker.sv
// rsec_checker: port-level assertions on the execute core, bound to the top.
// Depends on rv32_subset_execute_core.
`default_nettype none
module rsec_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata,
  input wire logic [0:0]  out_tuser
);
  // one word at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accept while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_illegal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> !out_tdata[32] && out_tdata[69:38] == 32'd0)
    else $error("illegal word wrote a register");

  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32] |-> out_tdata[37:33] != 5'd0)
    else $error("x0 reported written");
endmodule

bind rv32_subset_execute_core rsec_checker u_rsec_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
`default_nettype wire
